FILE: rtl/core/edq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edq_pkg
// Shared types and constants of the event debounce qualifier.
// ----------------------------------------------------------------------------
package edq_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_W      = 23;
	localparam int DEN_W      = 16;
	localparam int QUO_W      = 9;

	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAIL_CNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_CNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAIL_TIME = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_TIME = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TICK      = 3'd5;

	localparam logic [1:0] CMD_REPORT = 2'd0;
	localparam logic [1:0] CMD_RESET  = 2'd1;

	localparam logic [1:0] MODE_COUNTER = 2'd0;
	localparam logic [1:0] MODE_TIME    = 2'd1;
	localparam logic [1:0] MODE_PASSTHR = 2'd2;

	localparam logic [1:0] QS_PASSED    = 2'd0;
	localparam logic [1:0] QS_FAILED    = 2'd1;
	localparam logic [1:0] QS_PREPASSED = 2'd2;
	localparam logic [1:0] QS_PREFAILED = 2'd3;

	localparam logic [15:0] TIME_SAT = 16'hFFFF;
	localparam logic signed [7:0] FDC_MAX = 8'sd127;
	localparam logic signed [7:0] FDC_MIN = -8'sd128;

	typedef struct packed {
		logic [1:0] command;
		logic [5:0] event_index;
		logic [1:0] monitor_status;
		logic       test_failed;
		logic       not_completed_this_cycle;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        qualified_status;
		logic signed [7:0] fault_detection_counter;
		logic              temporarily_defective;
		logic              finally_defective;
		logic              frequently_detected;
		logic              test_complete;
	} out_word_t;

	typedef struct packed {
		logic [15:0] step_counter;
		logic [15:0] elapsed_time;
		logic        fail_direction;
	} entry_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_CALC,
		S_DIV,
		S_DONE
	} seq_state_t;

endpackage

FILE: rtl/core/edq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edq_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module edq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/edq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edq_div
// Restoring divider, one quotient bit per cycle, high bits first. Only the
// low QUO_W quotient bits are formed; a set top bit flags a quotient that
// is out of the 8-bit output range.
// ----------------------------------------------------------------------------
module edq_div (
	input  logic             clk,
	input  logic             arst_n,
	input  edq_pkg::div_req_t req,
	output edq_pkg::div_rsp_t rsp
);
	import edq_pkg::*;

	localparam int DSR_W  = DEN_W + QUO_W - 1;
	localparam int STEP_W = $clog2(QUO_W);

	logic [NUM_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;
	logic [NUM_W-1:0]  diff;

	assign ge   = DSR_W'(rem_q) >= dsr_q;
	assign diff = rem_q - dsr_q[NUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dsr_q <= {req.divisor, (QUO_W-1)'(0)};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff;
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsr_q <= dsr_q >> 1;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

FILE: rtl/core/event_debounce_qualifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_debounce_qualifier_unit
// Per-event fault debouncer with counter, time and pass-through qualification.
//
// Input channel in_valid/in_stall/in_data carries one command word: report a
// monitor status, reset an event's debounce entry, or query it. Output channel
// out_valid/out_stall/out_data returns one result word per command.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// written while the block is idle; the block itself does not enforce this.
// One word is worked at a time. A word that needs the fault detection counter
// division passes S_READ, S_CALC, S_DIV and S_DONE, where S_DIV waits on the
// 9-step restoring divider; the next word is taken once the result is loaded.
// Pass-through words and zero thresholds skip the divider (S_READ, S_CALC,
// S_DONE). The per-event state is one RAM, read once per word and written
// once per word whose event index is below NUM_EVENTS.
// After reset the block sweeps the event RAM to zero, one entry a cycle,
// through all NUM_EVENTS entries with in_stall high. A result waits in the
// output register while out_stall is high; the next word is accepted meanwhile
// but its result is held back until the register is free.
// ----------------------------------------------------------------------------
module event_debounce_qualifier_unit #(
	parameter int NUM_EVENTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  edq_pkg::in_word_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output edq_pkg::out_word_t                  out_data,
	input  logic                                cfg_we,
	input  logic [edq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [edq_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import edq_pkg::*;

	localparam int AW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;

	logic [1:0]  mode_q;
	logic [14:0] fthr_q;
	logic [15:0] pthr_q;
	logic [15:0] ftime_q;
	logic [15:0] ptime_q;
	logic [9:0]  tick_q;

	seq_state_t  state_q, state_n;
	logic [AW-1:0] clr_q;
	in_word_t    in_q;
	logic        hit_q;
	logic [15:0] cnt_q;
	logic [15:0] tim_q;
	logic        dir_q;
	logic [1:0]  qs_q;
	logic        temp_q, fin_q, freq_q, comp_q;
	logic        neg_q, use_div_q;
	logic signed [7:0] fdc_q;
	logic        out_valid_q;
	out_word_t   out_q;

	logic        accept;
	logic        out_load;
	entry_t      rd_entry, cur, nxt;
	logic [1:0]  qs_n;
	logic        ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t      ram_wdata;

	div_req_t    div_req;
	div_rsp_t    div_rsp;
	logic        use_div_n, neg_n;
	logic        temp_n, fin_n, freq_n;
	logic signed [7:0] fdc_dir_n;
	logic signed [7:0] fdc_out;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PASSTHR;
			fthr_q  <= 15'd127;
			pthr_q  <= 16'hFF80;
			ftime_q <= 16'd100;
			ptime_q <= 16'd100;
			tick_q  <= 10'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:      mode_q  <= cfg_data[1:0];
				REG_FAIL_CNT:  fthr_q  <= cfg_data[14:0];
				REG_PASS_CNT:  pthr_q  <= cfg_data;
				REG_FAIL_TIME: ftime_q <= cfg_data;
				REG_PASS_TIME: ptime_q <= cfg_data;
				REG_TICK:      tick_q  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	edq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(NUM_EVENTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (AW'(in_data.event_index)),
		.rdata (rd_entry)
	);

	assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_READ) && hit_q);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : AW'(in_q.event_index);
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : nxt;

	// entry update
	always_comb begin
		logic signed [16:0] cnt_x, fthr_x, pthr_x, cnt_i, cnt_d;
		logic               is_fail;
		logic [15:0]        base;
		logic [16:0]        sum;
		logic [15:0]        tim_n;
		cur     = hit_q ? rd_entry : '0;
		nxt     = cur;
		qs_n    = QS_PASSED;
		is_fail = (in_q.monitor_status == QS_FAILED) || (in_q.monitor_status == QS_PREFAILED);
		cnt_x   = {cur.step_counter[15], cur.step_counter};
		fthr_x  = {2'b00, fthr_q};
		pthr_x  = {pthr_q[15], pthr_q};
		cnt_i   = (cnt_x < fthr_x) ? cnt_x + 17'sd1 : cnt_x;
		cnt_d   = (cnt_x > pthr_x) ? cnt_x - 17'sd1 : cnt_x;
		base    = (is_fail != cur.fail_direction) ? 16'd0 : cur.elapsed_time;
		sum     = {1'b0, base} + 17'(tick_q);
		tim_n   = sum[16] ? TIME_SAT : sum[15:0];
		priority if (in_q.command == CMD_RESET) begin
			nxt = '0;
		end else if (in_q.command == CMD_REPORT) begin
			priority if (mode_q == MODE_COUNTER) begin
				if (is_fail) begin
					nxt.step_counter = cnt_i[15:0];
					qs_n = (cnt_i >= fthr_x) ? QS_FAILED : QS_PREFAILED;
				end else begin
					nxt.step_counter = cnt_d[15:0];
					qs_n = (cnt_d <= pthr_x) ? QS_PASSED : QS_PREPASSED;
				end
			end else if (mode_q == MODE_TIME) begin
				nxt.elapsed_time   = tim_n;
				nxt.fail_direction = is_fail;
				if (is_fail) begin
					qs_n = (tim_n >= ftime_q) ? QS_FAILED : QS_PREFAILED;
				end else begin
					qs_n = (tim_n >= ptime_q) ? QS_PASSED : QS_PREPASSED;
				end
			end else begin
				qs_n = is_fail ? QS_FAILED : QS_PASSED;
			end
		end else begin
			nxt = cur;
		end
	end

	// divider operands and state bits
	always_comb begin
		logic        cnt_pos, cnt_ge;
		logic [15:0] mag;
		logic [15:0] mul_in;
		mag       = cnt_q[15] ? 16'(~cnt_q + 16'd1) : cnt_q;
		cnt_pos   = !cnt_q[15] && (cnt_q != 16'd0);
		cnt_ge    = !cnt_q[15] && (cnt_q[14:0] >= fthr_q);
		mul_in    = (mode_q == MODE_COUNTER) ? mag : tim_q;
		use_div_n = 1'b0;
		neg_n     = 1'b0;
		temp_n    = 1'b0;
		fin_n     = 1'b0;
		freq_n    = 1'b0;
		fdc_dir_n = 8'sd0;
		div_req.dividend = (NUM_W'(mul_in) << 7) - NUM_W'(mul_in);
		div_req.divisor  = {1'b0, fthr_q};
		priority if (mode_q == MODE_COUNTER) begin
			use_div_n = (fthr_q != 15'd0);
			neg_n     = cnt_q[15];
			temp_n    = cnt_pos;
			freq_n    = cnt_pos;
			fin_n     = cnt_ge;
		end else if (mode_q == MODE_TIME) begin
			if (dir_q) begin
				div_req.divisor = ftime_q;
				use_div_n = (ftime_q != 16'd0);
				temp_n    = (tim_q != 16'd0);
				fin_n     = (tim_q >= ftime_q);
			end else begin
				div_req.dividend = NUM_W'(tim_q) << 7;
				div_req.divisor  = ptime_q;
				use_div_n = (ptime_q != 16'd0);
				neg_n     = 1'b1;
			end
		end else begin
			fdc_dir_n = in_q.test_failed ? FDC_MAX : FDC_MIN;
		end
		div_req.start = (state_q == S_CALC) && use_div_n;
	end

	edq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// saturate the quotient to the 8-bit counter range
	always_comb begin
		logic big;
		big = div_rsp.quotient[8] || div_rsp.quotient[7];
		priority if (!use_div_q) begin
			fdc_out = fdc_q;
		end else if (neg_q) begin
			fdc_out = big ? FDC_MIN : 8'sd0 - signed'({1'b0, div_rsp.quotient[6:0]});
		end else begin
			fdc_out = big ? FDC_MAX : signed'({1'b0, div_rsp.quotient[6:0]});
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(NUM_EVENTS - 1)) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_n = S_READ;
				end
			end
			S_READ: state_n = S_CALC;
			S_CALC: state_n = use_div_n ? S_DIV : S_DONE;
			S_DIV: begin
				if (div_rsp.done) begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q  <= in_data;
			hit_q <= int'(in_data.event_index) < NUM_EVENTS;
		end
		if (state_q == S_READ) begin
			cnt_q <= nxt.step_counter;
			tim_q <= nxt.elapsed_time;
			dir_q <= nxt.fail_direction;
			qs_q  <= qs_n;
		end
		if (state_q == S_CALC) begin
			use_div_q <= use_div_n;
			neg_q     <= neg_n;
			fdc_q     <= fdc_dir_n;
			temp_q    <= temp_n;
			fin_q     <= fin_n;
			freq_q    <= freq_n;
			comp_q    <= !(in_q.not_completed_this_cycle && !in_q.test_failed);
		end
		if (out_load) begin
			out_q.qualified_status        <= qs_q;
			out_q.fault_detection_counter <= fdc_out;
			out_q.temporarily_defective   <= temp_q;
			out_q.finally_defective       <= fin_q;
			out_q.frequently_detected     <= freq_q;
			out_q.test_complete           <= comp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_READ)
		else $error("accepted word did not start a RAM read");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> state_q == S_DIV)
		else $error("divider running outside the divide state");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished while sequencer not waiting");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_DONE)
		else $error("result word raised without a finished item");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the event debounce qualifier unit.
//
// Command words are sent through a sequence of register settings: reset
// values, counter and time modes, the spare mode code, zero and full-scale
// thresholds, a positive pass threshold, a zero tick and a tick of 1000. A
// scoreboard class keeps each event's step counter, elapsed time and direction.
// It predicts every result word in order and compares them field by field.
// Random traffic is mostly report bursts on a few events so that thresholds
// and saturation are reached. Both channels idle at random in the first eight phases.
// ----------------------------------------------------------------------------
module tb_top;
	import edq_pkg::*;

	localparam int EVENT_COUNT = 64;
	localparam int PHASES = 12;
	localparam int WORDS_PER_PHASE = 150;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	class debounce_tracker;
		logic [1:0]         mode_reg;
		logic [14:0]        fail_cnt_thr;
		logic signed [15:0] pass_cnt_thr;
		logic [15:0]        fail_time_thr;
		logic [15:0]        pass_time_thr;
		logic [9:0]         tick_step;
		logic signed [15:0] step_count [EVENT_COUNT];
		logic [15:0]        elapsed_ms [EVENT_COUNT];
		logic               toward_fail [EVENT_COUNT];
		out_word_t          expected_results [$];
		int                 errors;

		function new();
			mode_reg = MODE_PASSTHR;
			fail_cnt_thr = 15'd127;
			pass_cnt_thr = -16'sd128;
			fail_time_thr = 16'd100;
			pass_time_thr = 16'd100;
			tick_step = 10'd10;
			for (int i = 0; i < EVENT_COUNT; i++) begin
				step_count[i] = '0;
				elapsed_ms[i] = '0;
				toward_fail[i] = 1'b0;
			end
			errors = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_MODE: begin
					mode_reg = value[1:0];
				end
				REG_FAIL_CNT: begin
					fail_cnt_thr = value[14:0];
				end
				REG_PASS_CNT: begin
					pass_cnt_thr = value;
				end
				REG_FAIL_TIME: begin
					fail_time_thr = value;
				end
				REG_PASS_TIME: begin
					pass_time_thr = value;
				end
				REG_TICK: begin
					tick_step = value[9:0];
				end
				default: begin
				end
			endcase
		endfunction

		function logic signed [7:0] clamp_fdc(int v);
			if (v > 127)
				return FDC_MAX;
			if (v < -128)
				return FDC_MIN;
			return v[7:0];
		endfunction

		function void take_command(in_word_t w);
			int          cnt;
			int          fthr;
			int          pthr;
			int          fdc;
			int unsigned tim;
			logic        dir;
			logic        fail_side;
			logic [1:0]  mode;
			out_word_t   verdict;

			mode = (mode_reg == MODE_COUNTER || mode_reg == MODE_TIME) ? mode_reg : MODE_PASSTHR;
			cnt = int'(step_count[w.event_index]);
			tim = 32'(elapsed_ms[w.event_index]);
			dir = toward_fail[w.event_index];
			fthr = int'(fail_cnt_thr);
			pthr = int'(pass_cnt_thr);
			fail_side = (w.monitor_status == QS_FAILED) || (w.monitor_status == QS_PREFAILED);
			fdc = 0;
			verdict = '0;

			if (w.command == CMD_RESET) begin
				cnt = 0;
				tim = 0;
				dir = 1'b0;
			end else if (w.command == CMD_REPORT) begin
				if (mode == MODE_COUNTER) begin
					if (fail_side) begin
						if (cnt < fthr)
							cnt++;
						verdict.qualified_status = (cnt >= fthr) ? QS_FAILED : QS_PREFAILED;
					end else begin
						if (cnt > pthr)
							cnt--;
						verdict.qualified_status = (cnt <= pthr) ? QS_PASSED : QS_PREPASSED;
					end
				end else if (mode == MODE_TIME) begin
					if (fail_side != dir) begin
						tim = 0;
						dir = fail_side;
					end
					if (tim < TIME_SAT) begin
						tim += tick_step;
						if (tim > TIME_SAT)
							tim = TIME_SAT;
					end
					if (dir)
						verdict.qualified_status = (tim >= fail_time_thr) ? QS_FAILED : QS_PREFAILED;
					else
						verdict.qualified_status = (tim >= pass_time_thr) ? QS_PASSED : QS_PREPASSED;
				end else begin
					verdict.qualified_status = fail_side ? QS_FAILED : QS_PASSED;
				end
			end

			step_count[w.event_index] = cnt[15:0];
			elapsed_ms[w.event_index] = tim[15:0];
			toward_fail[w.event_index] = dir;

			if (mode == MODE_COUNTER) begin
				if (fthr != 0)
					fdc = (cnt * 127) / fthr;
				verdict.temporarily_defective = (cnt > 0);
				verdict.frequently_detected = (cnt > 0);
				verdict.finally_defective = (cnt >= fthr);
			end else if (mode == MODE_TIME) begin
				if (dir) begin
					if (fail_time_thr != 0)
						fdc = int'((tim * 127) / fail_time_thr);
					verdict.temporarily_defective = (tim > 0);
					verdict.finally_defective = (tim >= fail_time_thr);
				end else if (pass_time_thr != 0) begin
					fdc = -int'((tim * 128) / pass_time_thr);
				end
			end else begin
				fdc = w.test_failed ? 127 : -128;
			end
			verdict.fault_detection_counter = clamp_fdc(fdc);
			verdict.test_complete = !(w.not_completed_this_cycle && !w.test_failed);
			expected_results.push_back(verdict);
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;

			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: qs=%0d fdc=%0d", got.qualified_status,
						got.fault_detection_counter);
				return;
			end
			want = expected_results.pop_front();
			if (got.qualified_status !== want.qualified_status ||
				got.fault_detection_counter !== want.fault_detection_counter ||
				got.temporarily_defective !== want.temporarily_defective ||
				got.finally_defective !== want.finally_defective ||
				got.frequently_detected !== want.frequently_detected ||
				got.test_complete !== want.test_complete) begin
				errors++;
				if (errors <= 10)
					$display(
						"mismatch exp qs=%0d fdc=%0d st=%b%b%b%b got qs=%0d fdc=%0d st=%b%b%b%b",
						want.qualified_status, want.fault_detection_counter,
						want.temporarily_defective, want.finally_defective,
						want.frequently_detected, want.test_complete,
						got.qualified_status, got.fault_detection_counter,
						got.temporarily_defective, got.finally_defective,
						got.frequently_detected, got.test_complete);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_word_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_word_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	debounce_tracker tracker = new();

	event_debounce_qualifier_unit #(
		.NUM_EVENTS(EVENT_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(out_data);
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	function automatic in_word_t random_word();
		in_word_t w;

		w.command = 2'($urandom_range(0, 3));
		w.event_index = 6'($urandom_range(0, EVENT_COUNT - 1));
		w.monitor_status = 2'($urandom_range(0, 3));
		w.test_failed = 1'($urandom_range(0, 1));
		w.not_completed_this_cycle = 1'($urandom_range(0, 1));
		return w;
	endfunction

	// valid stays up from one word to the next unless the sender idles
	task automatic send_word(in_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do
			@(posedge clk);
		while (in_stall);
		tracker.take_command(w);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		tracker.set_register(idx, value);
	endtask

	task automatic apply_setting(int p);
		case (p)
			1: begin
				write_register(REG_MODE, 16'(MODE_COUNTER));
				write_register(REG_FAIL_CNT, 16'd6);
				write_register(REG_PASS_CNT, 16'(-20));
			end
			2: begin
				write_register(REG_MODE, 16'(MODE_TIME));
				write_register(REG_FAIL_TIME, 16'd40);
				write_register(REG_PASS_TIME, 16'd25);
				write_register(REG_TICK, 16'd7);
			end
			3: begin
				write_register(REG_MODE, 16'(MODE_SPARE));
			end
			4: begin
				write_register(REG_MODE, 16'(MODE_COUNTER));
				write_register(REG_FAIL_CNT, 16'd0);
				write_register(REG_PASS_CNT, 16'd3);
			end
			5: begin
				write_register(REG_MODE, 16'(MODE_TIME));
				write_register(REG_FAIL_TIME, 16'd0);
				write_register(REG_PASS_TIME, 16'd0);
				write_register(REG_TICK, 16'd1000);
			end
			6: begin
				write_register(REG_MODE, 16'(MODE_COUNTER));
				write_register(REG_FAIL_CNT, 16'd32767);
				write_register(REG_PASS_CNT, 16'h8000);
			end
			7: begin
				write_register(REG_MODE, 16'(MODE_TIME));
				write_register(REG_FAIL_TIME, 16'd65535);
				write_register(REG_PASS_TIME, 16'd65535);
				write_register(REG_TICK, 16'd1000);
			end
			8: begin
				write_register(REG_MODE, 16'(MODE_COUNTER));
				write_register(REG_FAIL_CNT, 16'd1);
				write_register(REG_PASS_CNT, 16'd0);
				write_register(REG_TICK, 16'd1);
			end
			9: begin
				write_register(REG_MODE, 16'(MODE_TIME));
				write_register(REG_TICK, 16'd0);
				write_register(REG_FAIL_TIME, 16'd0);
				write_register(REG_PASS_TIME, 16'd5);
			end
			10: begin
				write_register(REG_MODE, 16'(MODE_TIME));
				write_register(REG_TICK, 16'd1);
				write_register(REG_FAIL_TIME, 16'd3);
				write_register(REG_PASS_TIME, 16'd2);
			end
			11: begin
				write_register(REG_MODE, 16'($urandom_range(0, 3)));
				write_register(REG_FAIL_CNT, 16'($urandom_range(0, 12)));
				write_register(REG_PASS_CNT, 16'(-int'($urandom_range(0, 12))));
				write_register(REG_FAIL_TIME, 16'($urandom_range(0, 200)));
				write_register(REG_PASS_TIME, 16'($urandom_range(0, 200)));
				write_register(REG_TICK, 16'($urandom_range(1, 60)));
			end
			default: begin
			end
		endcase
		cfg_we <= 1'b0;
	endtask

	// report bursts on a few events, with some stray commands and noise words
	task automatic run_random(int count);
		int       sent;
		int       len;
		int       ev;
		logic     fail_side;
		in_word_t w;

		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) < 8) begin
				ev = ($urandom_range(0, 3) == 0) ? $urandom_range(0, EVENT_COUNT - 1) :
					$urandom_range(0, 3);
				fail_side = 1'($urandom_range(0, 1));
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
				for (int i = 0; i < len && sent < count; i++) begin
					w = random_word();
					w.event_index = 6'(ev);
					if ($urandom_range(0, 19) != 0)
						w.command = CMD_REPORT;
					// bit 0 of the status picks the direction
					w.monitor_status[0] = fail_side;
					send_word(w);
					sent++;
				end
			end else begin
				send_word(random_word());
				sent++;
			end
		end
	endtask

	initial begin
		in_word_t w;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct = (p < 4) ? 7 : ((p < 8) ? 51 : 0);
			recv_stall_pct = (p < 4) ? 51 : ((p < 8) ? 7 : 0);
			if (p != 0)
				apply_setting(p);
			if (p == 0) begin
				// every command and status code, both event ends, all flag pairs
				for (int k = 0; k < 16; k++) begin
					w.command = k[1:0];
					w.monitor_status = k[3:2];
					w.event_index = k[0] ? 6'd63 : 6'd0;
					w.test_failed = k[2] ^ k[0];
					w.not_completed_this_cycle = k[3] ^ k[1];
					send_word(w);
				end
			end
			if (p == 1) begin
				// walk one event up to the fail threshold, then query it and send the spare command
				w = '0;
				w.event_index = 6'd5;
				w.command = CMD_RESET;
				send_word(w);
				w.command = CMD_REPORT;
				for (int k = 0; k < 8; k++) begin
					w.monitor_status = k[0] ? QS_FAILED : QS_PREFAILED;
					w.test_failed = k[1];
					w.not_completed_this_cycle = k[2];
					send_word(w);
				end
				w.command = CMD_QUERY;
				send_word(w);
				w.command = CMD_SPARE;
				send_word(w);
			end
			run_random(WORDS_PER_PHASE);
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while (tracker.expected_results.size() != 0);
		end

		repeat (40) @(posedge clk);
		if (tracker.errors == 0 && tracker.expected_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
